FILE: sv/bba_pkg.sv
// bba_pkg: shared types and codes of the buddy allocator
// node and sibling-row layouts used by the top level and the row memory
`default_nettype none
package bba_pkg;

  localparam int ADDR_W  = 32;
  localparam int POOL_W  = 11;
  localparam int LEVEL_W = 5;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_IGNORED  = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;

  // configuration register indexes
  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_POOL = 1'b1;

  // one tree node: largest free run and split mark
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               split;
  } node_t;

  // both children of one parent node, stored together
  typedef struct packed {
    node_t left;
    node_t right;
  } row_t;

endpackage
`default_nettype wire

FILE: sv/buddy_allocator_best_fit_top.sv
// buddy_allocator_best_fit_top: best-fit buddy allocator over a block pool
// depends on bba_pkg and bba_row_ram
//
// usage:
//   a transaction is taken at a clock edge with start high and busy low;
//   operation selects allocate (request_size bytes) or free (free_address).
//   each transaction gives one result: done is high for one cycle with
//   address and status; the receiver cannot stall, so results are never held.
//   configuration: cfg_write with cfg_index 0 (base_address) or 1
//   (pool_blocks); writing pool_blocks empties the allocator.
// sequence:
//   a walk of d = tree depth minus chunk level runs through S_PREP and
//   S_CHECK, then one S_DOWN step per level down (one row read each, the
//   registered row memory read sets the pace) and one S_UP step per level
//   back up (one row write each). ignored requests (zero size, null or
//   outside address) answer from S_PREP, without a walk. a new transaction
//   is taken in the cycle done is shown.
// reset:
//   synchronous rst restores base 0, 1024 blocks and an unsplit free root;
//   only the root lives in flops, so no clearing pass of the memory is needed
`default_nettype none
module buddy_allocator_best_fit_top #(
  parameter int BLOCK_SHIFT = 10,
  parameter int TREE_LEVELS = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        operation,
  input  wire logic [bba_pkg::ADDR_W-1:0]  request_size,
  input  wire logic [bba_pkg::ADDR_W-1:0]  free_address,
  output logic                             done,
  output logic [bba_pkg::ADDR_W-1:0]       address,
  output logic [1:0]                       status,
  input  wire logic                        cfg_write,
  input  wire logic                        cfg_index,
  input  wire logic [bba_pkg::ADDR_W-1:0]  cfg_data
);
  import bba_pkg::*;

  localparam int BW = TREE_LEVELS + 1;
  localparam int IW = $clog2(TREE_LEVELS + 1);
  localparam int SD = 2**IW;
  localparam int CW = (BW > POOL_W) ? BW : POOL_W;
  localparam logic [BW-1:0] MAX_BLOCKS = BW'(1) << TREE_LEVELS;
  localparam logic [POOL_W-1:0] POOL_RESET = 11'd1024;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PREP  = 5'b00010,
    S_CHECK = 5'b00100,
    S_DOWN  = 5'b01000,
    S_UP    = 5'b10000
  } state_t;

  // pool size clipped to the tree
  function automatic logic [BW-1:0] eff_of(logic [POOL_W-1:0] p);
    logic [CW-1:0] pe;
    pe = CW'(p);
    if (pe > CW'(MAX_BLOCKS)) return MAX_BLOCKS;
    return BW'(pe);
  endfunction

  function automatic logic [LEVEL_W-1:0] flog_blk(logic [BW-1:0] v);
    logic [LEVEL_W-1:0] r;
    r = '0;
    for (int j = 0; j < BW; j++) begin
      if (v[j]) r = LEVEL_W'(j);
    end
    return r;
  endfunction

  function automatic logic [5:0] flog_word(logic [ADDR_W-1:0] v);
    logic [5:0] r;
    r = '0;
    for (int j = 0; j < ADDR_W; j++) begin
      if (v[j]) r = 6'(j);
    end
    return r;
  endfunction

  // depth of the tree in use
  function automatic logic [LEVEL_W-1:0] tree_ld(logic [BW-1:0] e);
    if (e <= BW'(1)) return '0;
    return flog_blk(e - BW'(1)) + LEVEL_W'(1);
  endfunction

  // free level of a fresh node at depth lvl starting at block off
  function automatic logic [LEVEL_W-1:0] cap(logic [LEVEL_W-1:0] lvl, logic [BW-1:0] off,
                                             logic [BW-1:0] e, logic [LEVEL_W-1:0] l);
    logic [LEVEL_W-1:0] span;
    logic [LEVEL_W-1:0] f;
    if (off >= e) return '0;
    span = l - lvl;
    f = flog_blk(e - off);
    return ((f < span) ? f : span) + LEVEL_W'(1);
  endfunction

  state_t state;
  logic                   op_free;
  logic [ADDR_W-1:0]      size_q;
  logic [ADDR_W-1:0]      addr_q;
  logic [ADDR_W-1:0]      base_q;
  logic [POOL_W-1:0]      pool_q;
  logic [LEVEL_W-1:0]     k_q;
  logic [IW-1:0]          d_q;
  logic [IW-1:0]          i_q;
  logic [TREE_LEVELS:0]   n_q;
  logic [TREE_LEVELS-1:0] off_q;
  logic [TREE_LEVELS-1:0] half_q;
  logic [TREE_LEVELS-1:0] path_q;
  node_t                  cur_q;
  node_t                  root_q;
  logic [LEVEL_W-1:0]     mf_q;
  row_t                   row_stk [SD];
  logic [LEVEL_W-1:0]     own_stk [SD];

  logic [LEVEL_W-1:0] chunk_log [2**TREE_LEVELS];
  logic [LEVEL_W-1:0] map_q;

  // pool geometry
  logic [BW-1:0]      eff;
  logic [LEVEL_W-1:0] tl;
  assign eff = eff_of(pool_q);
  assign tl  = tree_ld(eff);

  // rounded request level
  logic [5:0]         ceil_l;
  logic [LEVEL_W-1:0] k_alloc;
  always_comb begin
    ceil_l = flog_word(size_q - ADDR_W'(1)) + 6'd1;
    if ({1'b0, size_q} <= ((ADDR_W+1)'(1) << BLOCK_SHIFT)) begin
      k_alloc = '0;
    end else begin
      k_alloc = LEVEL_W'(ceil_l - 6'(BLOCK_SHIFT));
    end
  end

  // block index of a free
  logic [ADDR_W-1:0] blk;
  assign blk = (addr_q - base_q) >> BLOCK_SHIFT;

  // launch checks
  logic [LEVEL_W-1:0] kk;
  logic [LEVEL_W-1:0] d_lv;
  node_t              target;
  assign kk     = op_free ? map_q : k_q;
  assign d_lv   = tl - kk;
  assign target = op_free ? node_t'{level: kk + LEVEL_W'(1), split: 1'b0}
                          : node_t'{level: '0, split: 1'b0};

  // descent step
  row_t               row_q;
  row_t               caps;
  row_t               kids;
  logic [LEVEL_W-1:0] need;
  logic [LEVEL_W-1:0] lvl_child;
  logic [LEVEL_W-1:0] own_max;
  logic               dir;
  logic [TREE_LEVELS:0] n_dn;
  always_comb begin
    need      = k_q + LEVEL_W'(1);
    lvl_child = LEVEL_W'(i_q) + LEVEL_W'(1);
    caps.left.level  = cap(lvl_child, BW'(off_q), eff, tl);
    caps.left.split  = 1'b0;
    caps.right.level = cap(lvl_child, BW'(off_q) + BW'(half_q), eff, tl);
    caps.right.split = 1'b0;
    if (cur_q.split) begin
      kids = row_q;
    end else if (op_free) begin
      kids = '0;
    end else begin
      kids = caps;
    end
    own_max = (cur_q.level < need) ? need : cur_q.level;
    if (op_free) begin
      dir = path_q[TREE_LEVELS-1];
    end else begin
      dir = !(kids.left.level >= need &&
              !(kids.right.level < kids.left.level && kids.right.level >= need));
    end
    n_dn = {n_q[TREE_LEVELS-1:0], dir};
  end

  // ascent step
  row_t               up_row;
  node_t              parent;
  logic [LEVEL_W-1:0] cl;
  logic [LEVEL_W-1:0] amax;
  logic [LEVEL_W-1:0] fmax;
  logic               joined;
  always_comb begin
    up_row = row_stk[i_q];
    if (n_q[0]) begin
      up_row.right = cur_q;
    end else begin
      up_row.left = cur_q;
    end
    cl     = tl - LEVEL_W'(i_q);
    amax   = (up_row.left.level > up_row.right.level) ? up_row.left.level
                                                      : up_row.right.level;
    fmax   = (mf_q > own_stk[i_q]) ? mf_q : own_stk[i_q];
    joined = up_row.left.level == cl && up_row.right.level == cl;
    if (!op_free) begin
      parent = node_t'{level: amax, split: amax != '0};
    end else if (joined) begin
      parent = node_t'{level: cl + LEVEL_W'(1), split: 1'b0};
    end else begin
      parent = node_t'{level: fmax, split: 1'b1};
    end
  end

  // row memory hookup
  logic                   row_we;
  logic [TREE_LEVELS-1:0] row_wa;
  logic [TREE_LEVELS-1:0] row_ra;
  assign row_we = state == S_UP;
  assign row_wa = n_q[TREE_LEVELS:1];
  assign row_ra = (state == S_DOWN) ? n_dn[TREE_LEVELS-1:0] : TREE_LEVELS'(1);

  bba_row_ram #(
    .ADDR_BITS(TREE_LEVELS)
  ) u_rows (
    .clk     (clk),
    .wr_en   (row_we),
    .wr_addr (row_wa),
    .wr_data (up_row),
    .rd_addr (row_ra),
    .rd_data (row_q)
  );

  // size map write on a finished allocate
  logic                   map_we;
  logic [TREE_LEVELS-1:0] map_wa;
  logic [LEVEL_W-1:0]     map_wd;
  always_comb begin
    map_we = 1'b0;
    map_wa = off_q;
    map_wd = k_q;
    if (!op_free && state == S_CHECK && kk <= tl && root_q.level >= kk + LEVEL_W'(1) &&
        d_lv == '0) begin
      map_we = 1'b1;
      map_wa = '0;
      map_wd = kk;
    end else if (!op_free && state == S_UP && i_q == '0) begin
      map_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      chunk_log[map_wa] <= map_wd;
    end
    map_q <= chunk_log[blk[TREE_LEVELS-1:0]];
  end

  // allocated address
  logic [TREE_LEVELS+BLOCK_SHIFT-1:0] off_bytes;
  assign off_bytes = {off_q, {BLOCK_SHIFT{1'b0}}};

  assign busy = state != S_IDLE;

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      base_q <= '0;
      pool_q <= POOL_RESET;
      root_q <= node_t'{level: cap('0, '0, eff_of(POOL_RESET),
                                   tree_ld(eff_of(POOL_RESET))), split: 1'b0};
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_free <= operation;
            size_q  <= request_size;
            addr_q  <= free_address;
            state   <= S_PREP;
          end
        end
        S_PREP: begin
          k_q    <= k_alloc;
          path_q <= blk[TREE_LEVELS-1:0] << (LEVEL_W'(TREE_LEVELS) - tl);
          if ((!op_free && size_q == '0) || (op_free && addr_q == '0) ||
              (op_free && blk >= ADDR_W'(eff))) begin
            done    <= 1'b1;
            address <= '0;
            status  <= ST_IGNORED;
            state   <= S_IDLE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          k_q    <= kk;
          d_q    <= IW'(d_lv);
          i_q    <= '0;
          n_q    <= (TREE_LEVELS+1)'(1);
          off_q  <= '0;
          half_q <= TREE_LEVELS'(1) << (tl - LEVEL_W'(1));
          cur_q  <= root_q;
          mf_q   <= '0;
          if (kk > tl) begin
            done    <= 1'b1;
            address <= '0;
            status  <= op_free ? ST_IGNORED : ST_NO_SPACE;
            state   <= S_IDLE;
          end else if (!op_free && root_q.level < kk + LEVEL_W'(1)) begin
            done    <= 1'b1;
            address <= '0;
            status  <= ST_NO_SPACE;
            state   <= S_IDLE;
          end else if (d_lv == '0) begin
            root_q  <= target;
            done    <= 1'b1;
            address <= op_free ? '0 : base_q;
            status  <= ST_DONE;
            state   <= S_IDLE;
          end else begin
            state <= S_DOWN;
          end
        end
        S_DOWN: begin
          row_stk[i_q] <= kids;
          own_stk[i_q] <= own_max;
          n_q    <= n_dn;
          off_q  <= off_q | (dir ? half_q : '0);
          half_q <= half_q >> 1;
          path_q <= path_q << 1;
          if (i_q == d_q - IW'(1)) begin
            cur_q <= op_free ? node_t'{level: need, split: 1'b0}
                             : node_t'{level: '0, split: 1'b0};
            state <= S_UP;
          end else begin
            cur_q <= dir ? kids.right : kids.left;
            i_q   <= i_q + IW'(1);
          end
        end
        S_UP: begin
          n_q   <= n_q >> 1;
          cur_q <= parent;
          if (op_free && joined) begin
            mf_q <= cl + LEVEL_W'(1);
          end
          if (i_q == '0) begin
            root_q  <= parent;
            done    <= 1'b1;
            address <= op_free ? '0 : base_q + ADDR_W'(off_bytes);
            status  <= ST_DONE;
            state   <= S_IDLE;
          end else begin
            i_q <= i_q - IW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // configuration writes, to be taken only while idle; the user must keep to this, the block does not enforce it
      if (cfg_write) begin
        if (cfg_index == CFG_BASE) begin
          base_q <= cfg_data;
        end else begin
          pool_q <= cfg_data[POOL_W-1:0];
          root_q <= node_t'{level: cap('0, '0, eff_of(cfg_data[POOL_W-1:0]),
                                       tree_ld(eff_of(cfg_data[POOL_W-1:0]))),
                            split: 1'b0};
        end
      end
    end
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");
  a_take: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("transaction taken but sequencer idle");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
      done && status != ST_DONE |-> address == '0)
    else $error("failed request with nonzero address");
  a_write_up: assert property (@(posedge clk) disable iff (rst) row_we |-> state == S_UP)
    else $error("row write outside ascent");
  a_down_next: assert property (@(posedge clk) disable iff (rst)
      state == S_DOWN |=> state == S_DOWN || state == S_UP)
    else $error("descent left without ascent");

endmodule
`default_nettype wire

FILE: sv/bba_row_ram.sv
// bba_row_ram: sibling-pair memory of the allocator tree, indexed by parent node
// one write port, one read port with registered data; depends on bba_pkg
`default_nettype none
module bba_row_ram #(
  parameter int ADDR_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire bba_pkg::row_t        wr_data,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output bba_pkg::row_t             rd_data
);
  import bba_pkg::*;

  row_t mem [2**ADDR_BITS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire
